// ===== hw/rtl/tpp_pkg.sv =====
package tpp_pkg;

  localparam int TPP_MAX_STEPS         = 256;
  localparam int TPP_MAX_EDGES         = 64;
  localparam int TPP_MAX_SEGMENTS      = 1024;
  localparam int TPP_MAX_EDGE_SEGMENTS = 64;

  localparam int IN_DATA_W  = 160;
  localparam int OUT_DATA_W = 88;

  // heading window: 6 map units in Q16.8
  localparam logic [25:0] HEAD_WINDOW = 26'd1536;
  localparam logic [5:0]  DIV_STEPS   = 6'd56;

  typedef enum logic [1:0] {
    ACT_STEP  = 2'd0,
    ACT_EDGE  = 2'd1,
    ACT_SEG   = 2'd2,
    ACT_QUERY = 2'd3
  } tpp_act_t;

  typedef enum logic [5:0] {
    OP_NONE, OP_LATCH, OP_WRITE, OP_RD_LAST, OP_DIV_MOD, OP_TAKE_T,
    OP_RD_STEP, OP_SCAN_ADV, OP_STEP_TAKE, OP_RD_EDGE, OP_EDGE_TAKE,
    OP_LEN_MUL, OP_DIV_LEN, OP_TAKE_LEN, OP_SEG_ADDR, OP_WRAP, OP_SEG_RD,
    OP_BS_LO, OP_BS_HI, OP_LO_TAKE, OP_PRV_TAKE, OP_OFF, OP_X_MUL,
    OP_DIV_X, OP_TAKE_X, OP_Y_MUL, OP_DIV_Y, OP_TAKE_Y, OP_LEFT_DEC,
    OP_RIGHT_INC, OP_HL_TAKE, OP_HR_TAKE, OP_EMIT_HIT, OP_EMIT_MISS
  } dp_op_t;

  typedef enum logic [2:0] {
    SEL_MID, SEL_LO, SEL_LO_M1, SEL_LEFT_M1, SEL_LEFT, SEL_RIGHT
  } seg_sel_t;

  typedef struct packed {
    dp_op_t   op;
    seg_sel_t sel;
  } tpp_cmd_t;

  typedef struct packed {
    logic in_query;
    logic cnt_zero;
    logic dur_zero;
    logic div_busy;
    logic scan_more;
    logic geo_bad;
    logic lo_lt_hi;
    logic go_right;
    logic lo_nz;
    logic left_nz;
    logic left_more;
    logic right_room;
    logic right_more;
    logic wrap_need;
    logic out_free;
  } tpp_sts_t;

endpackage

// ===== hw/rtl/tpp_ctrl.sv =====
module tpp_ctrl import tpp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  tpp_sts_t sts,
  output tpp_cmd_t cmd
);

  typedef enum logic [34:0] {
    ST_IDLE      = 35'd1 << 0,
    ST_WR        = 35'd1 << 1,
    ST_Q_LAST    = 35'd1 << 2,
    ST_Q_DUR     = 35'd1 << 3,
    ST_MOD_W     = 35'd1 << 4,
    ST_SC_RD     = 35'd1 << 5,
    ST_SC_CMP    = 35'd1 << 6,
    ST_ED_RD     = 35'd1 << 7,
    ST_ED_TAKE   = 35'd1 << 8,
    ST_LEN_MUL   = 35'd1 << 9,
    ST_LEN_DIV   = 35'd1 << 10,
    ST_LEN_W     = 35'd1 << 11,
    ST_BS_CHK    = 35'd1 << 12,
    ST_BS_CMP    = 35'd1 << 13,
    ST_SG_WRAP   = 35'd1 << 14,
    ST_LO_TAKE   = 35'd1 << 15,
    ST_PRV_CHK   = 35'd1 << 16,
    ST_PRV_TAKE  = 35'd1 << 17,
    ST_OFF       = 35'd1 << 18,
    ST_X_MUL     = 35'd1 << 19,
    ST_X_DIV     = 35'd1 << 20,
    ST_X_W       = 35'd1 << 21,
    ST_Y_MUL     = 35'd1 << 22,
    ST_Y_DIV     = 35'd1 << 23,
    ST_Y_W       = 35'd1 << 24,
    ST_LF_CHK    = 35'd1 << 25,
    ST_LF_CMP    = 35'd1 << 26,
    ST_RT_CHK    = 35'd1 << 27,
    ST_RT_CMP    = 35'd1 << 28,
    ST_HL_RD     = 35'd1 << 29,
    ST_HL_TAKE   = 35'd1 << 30,
    ST_HR_RD     = 35'd1 << 31,
    ST_HR_TAKE   = 35'd1 << 32,
    ST_EMIT_HIT  = 35'd1 << 33,
    ST_EMIT_MISS = 35'd1 << 34
  } state_t;

  state_t state, state_next;
  state_t ret, ret_next;

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ret   <= ST_IDLE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  always_comb begin
    state_next = state;
    ret_next   = ret;
    cmd.op     = OP_NONE;
    cmd.sel    = SEL_LO;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.op     = OP_LATCH;
          state_next = sts.in_query ? ST_Q_LAST : ST_WR;
        end
      end
      ST_WR: begin
        cmd.op     = OP_WRITE;
        state_next = ST_IDLE;
      end
      ST_Q_LAST: begin
        if (sts.cnt_zero) begin
          state_next = ST_EMIT_MISS;
        end else begin
          cmd.op     = OP_RD_LAST;
          state_next = ST_Q_DUR;
        end
      end
      ST_Q_DUR: begin
        if (sts.dur_zero) begin
          state_next = ST_EMIT_MISS;
        end else begin
          cmd.op     = OP_DIV_MOD;
          state_next = ST_MOD_W;
        end
      end
      ST_MOD_W: begin
        if (!sts.div_busy) begin
          cmd.op     = OP_TAKE_T;
          state_next = ST_SC_RD;
        end
      end
      ST_SC_RD: begin
        cmd.op     = OP_RD_STEP;
        state_next = ST_SC_CMP;
      end
      ST_SC_CMP: begin
        if (sts.scan_more) begin
          cmd.op     = OP_SCAN_ADV;
          state_next = ST_SC_RD;
        end else begin
          cmd.op     = OP_STEP_TAKE;
          state_next = sts.geo_bad ? ST_EMIT_MISS : ST_ED_RD;
        end
      end
      ST_ED_RD: begin
        cmd.op     = OP_RD_EDGE;
        state_next = ST_ED_TAKE;
      end
      ST_ED_TAKE: begin
        cmd.op     = OP_EDGE_TAKE;
        state_next = ST_LEN_MUL;
      end
      ST_LEN_MUL: begin
        cmd.op     = OP_LEN_MUL;
        state_next = ST_LEN_DIV;
      end
      ST_LEN_DIV: begin
        cmd.op     = OP_DIV_LEN;
        state_next = ST_LEN_W;
      end
      ST_LEN_W: begin
        if (!sts.div_busy) begin
          cmd.op     = OP_TAKE_LEN;
          state_next = ST_BS_CHK;
        end
      end
      ST_BS_CHK: begin
        cmd.op     = OP_SEG_ADDR;
        state_next = ST_SG_WRAP;
        if (sts.lo_lt_hi) begin
          cmd.sel  = SEL_MID;
          ret_next = ST_BS_CMP;
        end else begin
          cmd.sel  = SEL_LO;
          ret_next = ST_LO_TAKE;
        end
      end
      ST_BS_CMP: begin
        cmd.op     = sts.go_right ? OP_BS_LO : OP_BS_HI;
        state_next = ST_BS_CHK;
      end
      ST_SG_WRAP: begin
        if (sts.wrap_need) begin
          cmd.op = OP_WRAP;
        end else begin
          cmd.op     = OP_SEG_RD;
          state_next = ret;
        end
      end
      ST_LO_TAKE: begin
        cmd.op     = OP_LO_TAKE;
        state_next = ST_PRV_CHK;
      end
      ST_PRV_CHK: begin
        if (sts.lo_nz) begin
          cmd.op     = OP_SEG_ADDR;
          cmd.sel    = SEL_LO_M1;
          ret_next   = ST_PRV_TAKE;
          state_next = ST_SG_WRAP;
        end else begin
          state_next = ST_OFF;
        end
      end
      ST_PRV_TAKE: begin
        cmd.op     = OP_PRV_TAKE;
        state_next = ST_OFF;
      end
      ST_OFF: begin
        cmd.op     = OP_OFF;
        state_next = ST_X_MUL;
      end
      ST_X_MUL: begin
        cmd.op     = OP_X_MUL;
        state_next = ST_X_DIV;
      end
      ST_X_DIV: begin
        cmd.op     = OP_DIV_X;
        state_next = ST_X_W;
      end
      ST_X_W: begin
        if (!sts.div_busy) begin
          cmd.op     = OP_TAKE_X;
          state_next = ST_Y_MUL;
        end
      end
      ST_Y_MUL: begin
        cmd.op     = OP_Y_MUL;
        state_next = ST_Y_DIV;
      end
      ST_Y_DIV: begin
        cmd.op     = OP_DIV_Y;
        state_next = ST_Y_W;
      end
      ST_Y_W: begin
        if (!sts.div_busy) begin
          cmd.op     = OP_TAKE_Y;
          state_next = ST_LF_CHK;
        end
      end
      ST_LF_CHK: begin
        if (sts.left_nz) begin
          cmd.op     = OP_SEG_ADDR;
          cmd.sel    = SEL_LEFT_M1;
          ret_next   = ST_LF_CMP;
          state_next = ST_SG_WRAP;
        end else begin
          state_next = ST_RT_CHK;
        end
      end
      ST_LF_CMP: begin
        if (sts.left_more) begin
          cmd.op     = OP_LEFT_DEC;
          state_next = ST_LF_CHK;
        end else begin
          state_next = ST_RT_CHK;
        end
      end
      ST_RT_CHK: begin
        if (sts.right_room) begin
          cmd.op     = OP_SEG_ADDR;
          cmd.sel    = SEL_RIGHT;
          ret_next   = ST_RT_CMP;
          state_next = ST_SG_WRAP;
        end else begin
          state_next = ST_HL_RD;
        end
      end
      ST_RT_CMP: begin
        if (sts.right_more) begin
          cmd.op     = OP_RIGHT_INC;
          state_next = ST_RT_CHK;
        end else begin
          state_next = ST_HL_RD;
        end
      end
      ST_HL_RD: begin
        cmd.op     = OP_SEG_ADDR;
        cmd.sel    = SEL_LEFT;
        ret_next   = ST_HL_TAKE;
        state_next = ST_SG_WRAP;
      end
      ST_HL_TAKE: begin
        cmd.op     = OP_HL_TAKE;
        state_next = ST_HR_RD;
      end
      ST_HR_RD: begin
        cmd.op     = OP_SEG_ADDR;
        cmd.sel    = SEL_RIGHT;
        ret_next   = ST_HR_TAKE;
        state_next = ST_SG_WRAP;
      end
      ST_HR_TAKE: begin
        cmd.op     = OP_HR_TAKE;
        state_next = ST_EMIT_HIT;
      end
      ST_EMIT_HIT: begin
        if (sts.out_free) begin
          cmd.op     = OP_EMIT_HIT;
          state_next = ST_IDLE;
        end
      end
      ST_EMIT_MISS: begin
        if (sts.out_free) begin
          cmd.op     = OP_EMIT_MISS;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/tpp_dp.sv =====
module tpp_dp import tpp_pkg::*; #(
  parameter int MAX_STEPS         = TPP_MAX_STEPS,
  parameter int MAX_EDGES         = TPP_MAX_EDGES,
  parameter int MAX_SEGMENTS      = TPP_MAX_SEGMENTS,
  parameter int MAX_EDGE_SEGMENTS = TPP_MAX_EDGE_SEGMENTS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  tpp_cmd_t              cmd,
  output tpp_sts_t              sts,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [1:0]            s_tuser,
  input  logic                  cfg_valid,
  input  logic [8:0]            cfg_data,
  input  logic                  m_tready,
  output logic                  m_tvalid,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tuser
);

  localparam int SW = $clog2(MAX_STEPS);
  localparam int CW = $clog2(MAX_STEPS + 1);
  localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int GW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int NW = $clog2(MAX_EDGE_SEGMENTS + 1);

  logic [8:0] step_count;

  // latched input item
  logic [1:0]  in_act;
  logic [9:0]  in_idx;
  logic [6:0]  in_geo;
  logic        in_rev;
  logic [31:0] in_time;
  logic [63:0] in_pts;
  logic [23:0] in_len;
  logic [9:0]  in_ef;
  logic [6:0]  in_ec;

  logic [39:0] stp_mem [MAX_STEPS];
  logic [40:0] edg_mem [MAX_EDGES];
  logic [87:0] seg_mem [MAX_SEGMENTS];
  logic [39:0] stp_q;
  logic [40:0] edg_q;
  logic [87:0] seg_q;

  logic [16:0]   idx_w;
  logic [CW-1:0] cnt_c, cnt_m1, s;
  logic [SW-1:0] stp_ra;
  logic [10:0]   geo_w;

  logic [31:0]        t, start, el, a_r, stp_end_q;
  logic signed [32:0] span;
  logic               span_pos;
  logic [5:0]         geo_r;
  logic               rev_r;
  logic [9:0]         base;
  logic [NW-1:0]      n, lo, hi, mid, left, right, k;
  logic [10:0]        segs_w;
  logic [23:0]        total, len, end_lo, seg_prev, seg_end_q;
  logic [55:0]        len_prod;
  logic [11:0]        seg_sum;
  logic [16:0]        sum_w;
  logic [31:0]        elc;

  logic [63:0]        pts_lo;
  logic signed [24:0] sspan_c, off_s;
  logic               sspan_pos;
  logic [23:0]        off_c;
  logic signed [16:0] diff;
  logic signed [41:0] iprod;
  logic [41:0]        iabs;
  logic [49:0]        ip_abs;
  logic               ip_neg;
  logic [55:0]        ires;
  logic [23:0]        pos_x, pos_y;
  logic [15:0]        lx0, ly0;
  logic signed [16:0] hx, hy, head_dx, head_dy;

  // shared restoring divider, one quotient bit per cycle
  logic [31:0] dv_rem, dv_div;
  logic [55:0] dv_quo;
  logic [5:0]  dv_cnt;
  logic [32:0] dv_sh;
  logic        dv_ge;
  logic [55:0] dv_dividend;
  logic [31:0] dv_divisor;

  assign idx_w     = 17'(in_idx);
  assign cnt_c     = (13'(step_count) > 13'(MAX_STEPS)) ? CW'(MAX_STEPS) : CW'(step_count);
  assign cnt_m1    = cnt_c - CW'(1);
  assign stp_ra    = (cmd.op == OP_RD_LAST) ? cnt_m1[SW-1:0] : s[SW-1:0];
  assign stp_end_q = stp_q[39:8];
  assign geo_w     = 11'(geo_r);
  assign seg_end_q = seg_q[87:64];
  assign sum_w     = 17'(seg_sum);
  assign mid       = lo + ((hi - lo) >> 1);

  always_ff @(posedge clk) begin
    if (cmd.op == OP_WRITE && in_act == ACT_STEP && idx_w < 17'(MAX_STEPS)) begin
      stp_mem[idx_w[SW-1:0]] <= {in_time, in_rev, in_geo};
    end
    if (cmd.op == OP_RD_LAST || cmd.op == OP_RD_STEP) begin
      stp_q <= stp_mem[stp_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_WRITE && in_act == ACT_EDGE && idx_w < 17'(MAX_EDGES)) begin
      edg_mem[idx_w[EW-1:0]] <= {in_len, in_ec, in_ef};
    end
    if (cmd.op == OP_RD_EDGE) begin
      edg_q <= edg_mem[geo_w[EW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_WRITE && in_act == ACT_SEG && idx_w < 17'(MAX_SEGMENTS)) begin
      seg_mem[idx_w[GW-1:0]] <= {in_len, in_pts};
    end
    if (cmd.op == OP_SEG_RD) begin
      seg_q <= seg_mem[sum_w[GW-1:0]];
    end
  end

  always_comb begin
    unique case (cmd.sel)
      SEL_MID:     k = mid;
      SEL_LO:      k = lo;
      SEL_LO_M1:   k = lo - NW'(1);
      SEL_LEFT_M1: k = left - NW'(1);
      SEL_LEFT:    k = left;
      SEL_RIGHT:   k = right;
      default:     k = lo;
    endcase
  end

  always_comb begin
    segs_w = 11'(edg_q[16:10]);
    if (segs_w == 11'd0) begin
      segs_w = 11'd1;
    end else if (segs_w > 11'(MAX_EDGE_SEGMENTS)) begin
      segs_w = 11'(MAX_EDGE_SEGMENTS);
    end
    elc = ({1'b0, el} > span) ? span[31:0] : el;
  end

  always_comb begin
    sspan_c = $signed({1'b0, end_lo}) - $signed({1'b0, seg_prev});
    off_s   = $signed({1'b0, len}) - $signed({1'b0, seg_prev});
    diff    = (cmd.op == OP_X_MUL)
            ? $signed({pts_lo[47], pts_lo[47:32]}) - $signed({pts_lo[15], pts_lo[15:0]})
            : $signed({pts_lo[63], pts_lo[63:48]}) - $signed({pts_lo[31], pts_lo[31:16]});
    iprod   = diff * $signed({1'b0, off_c});
    iabs    = iprod[41] ? 42'(-iprod) : 42'(iprod);
    ires    = ip_neg ? 56'(-(dv_quo + 56'(dv_rem != 32'd0))) : dv_quo;
    hx      = $signed({seg_q[47], seg_q[47:32]}) - $signed({lx0[15], lx0});
    hy      = $signed({seg_q[63], seg_q[63:48]}) - $signed({ly0[15], ly0});
  end

  always_comb begin
    unique case (cmd.op)
      OP_DIV_MOD: begin
        dv_dividend = 56'(in_time);
        dv_divisor  = stp_end_q;
      end
      OP_DIV_LEN: begin
        dv_dividend = len_prod;
        dv_divisor  = span_pos ? span[31:0] : 32'd1;
      end
      default: begin
        dv_dividend = 56'(ip_abs);
        dv_divisor  = sspan_pos ? 32'(end_lo - seg_prev) : 32'd1;
      end
    endcase
    dv_sh = {dv_rem, dv_quo[55]};
    dv_ge = dv_sh >= {1'b0, dv_div};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_cnt <= '0;
    end else if (cmd.op == OP_DIV_MOD || cmd.op == OP_DIV_LEN ||
                 cmd.op == OP_DIV_X || cmd.op == OP_DIV_Y) begin
      dv_cnt <= DIV_STEPS;
    end else if (dv_cnt != 6'd0) begin
      dv_cnt <= dv_cnt - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_DIV_MOD || cmd.op == OP_DIV_LEN ||
        cmd.op == OP_DIV_X || cmd.op == OP_DIV_Y) begin
      dv_quo <= dv_dividend;
      dv_div <= dv_divisor;
      dv_rem <= '0;
    end else if (dv_cnt != 6'd0) begin
      dv_rem <= dv_ge ? 32'(dv_sh - {1'b0, dv_div}) : dv_sh[31:0];
      dv_quo <= {dv_quo[54:0], dv_ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_count <= '0;
    end else if (cfg_valid) begin
      step_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LATCH: begin
        in_act  <= s_tuser;
        in_idx  <= s_tdata[9:0];
        in_geo  <= s_tdata[16:10];
        in_rev  <= s_tdata[17];
        in_time <= s_tdata[49:18];
        in_pts  <= s_tdata[113:50];
        in_len  <= s_tdata[137:114];
        in_ef   <= s_tdata[147:138];
        in_ec   <= s_tdata[154:148];
      end
      OP_TAKE_T: begin
        t     <= dv_rem;
        s     <= '0;
        start <= '0;
      end
      OP_SCAN_ADV: begin
        start <= stp_end_q;
        s     <= s + CW'(1);
      end
      OP_STEP_TAKE: begin
        span  <= $signed({1'b0, stp_end_q}) - $signed({1'b0, start});
        el    <= t - start;
        geo_r <= stp_q[5:0];
        rev_r <= stp_q[7];
      end
      OP_EDGE_TAKE: begin
        base     <= edg_q[9:0];
        n        <= NW'(segs_w);
        total    <= edg_q[40:17];
        span_pos <= !span[32] && (span != 33'sd0);
        if (!span[32] && (span != 33'sd0)) begin
          a_r <= rev_r ? (span[31:0] - elc) : elc;
        end else begin
          a_r <= '0;
        end
      end
      OP_LEN_MUL: len_prod <= a_r * total;
      OP_TAKE_LEN: begin
        len <= dv_quo[23:0];
        lo  <= '0;
        hi  <= n - NW'(1);
      end
      OP_SEG_ADDR:  seg_sum <= 12'(base) + 12'(k);
      OP_WRAP:      seg_sum <= seg_sum - 12'(MAX_SEGMENTS);
      OP_BS_LO:     lo <= mid + NW'(1);
      OP_BS_HI:     hi <= mid;
      OP_LO_TAKE: begin
        pts_lo   <= seg_q[63:0];
        end_lo   <= seg_end_q;
        seg_prev <= '0;
        left     <= lo;
        right    <= lo;
      end
      OP_PRV_TAKE: seg_prev <= seg_end_q;
      OP_OFF: begin
        sspan_pos <= sspan_c > 25'sd0;
        if (sspan_c <= 25'sd0 || off_s < 25'sd0) begin
          off_c <= '0;
        end else if (off_s > sspan_c) begin
          off_c <= sspan_c[23:0];
        end else begin
          off_c <= off_s[23:0];
        end
      end
      OP_X_MUL, OP_Y_MUL: begin
        ip_neg <= iprod[41];
        ip_abs <= {iabs, 8'd0};
      end
      OP_TAKE_X:    pos_x <= {pts_lo[15:0], 8'd0} + ires[23:0];
      OP_TAKE_Y:    pos_y <= {pts_lo[31:16], 8'd0} + ires[23:0];
      OP_LEFT_DEC:  left <= left - NW'(1);
      OP_RIGHT_INC: right <= right + NW'(1);
      OP_HL_TAKE: begin
        lx0 <= seg_q[15:0];
        ly0 <= seg_q[31:16];
      end
      OP_HR_TAKE: begin
        head_dx <= rev_r ? -hx : hx;
        head_dy <= rev_r ? -hy : hy;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.op == OP_EMIT_HIT || cmd.op == OP_EMIT_MISS) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT_HIT) begin
      m_tdata <= {geo_r, head_dy, head_dx, pos_y, pos_x};
      m_tuser <= 1'b1;
    end else if (cmd.op == OP_EMIT_MISS) begin
      m_tdata <= '0;
      m_tuser <= 1'b0;
    end
  end

  always_comb begin
    sts.in_query   = (s_tuser == ACT_QUERY);
    sts.cnt_zero   = (cnt_c == '0);
    sts.dur_zero   = (stp_end_q == 32'd0);
    sts.div_busy   = (dv_cnt != 6'd0);
    sts.scan_more  = ((CW+1)'(s) + (CW+1)'(1) < (CW+1)'(cnt_c)) && (t >= stp_end_q);
    sts.geo_bad    = stp_q[6] || (11'(stp_q[5:0]) >= 11'(MAX_EDGES));
    sts.lo_lt_hi   = (lo < hi);
    sts.go_right   = (seg_end_q < len);
    sts.lo_nz      = (lo != '0);
    sts.left_nz    = (left != '0);
    sts.left_more  = $signed({2'b0, seg_end_q}) > ($signed({2'b0, len}) - $signed(HEAD_WINDOW));
    sts.right_room = ((NW+1)'(right) + (NW+1)'(1)) < (NW+1)'(n);
    sts.right_more = ({2'b0, seg_end_q} < ({2'b0, len} + HEAD_WINDOW));
    sts.wrap_need  = (sum_w >= 17'(MAX_SEGMENTS));
    sts.out_free   = !m_tvalid || m_tready;
  end

endmodule

// ===== hw/rtl/timed_polyline_position_unit.sv =====
// Timed polyline position unit.
// s_* channel takes items; s_tuser selects the action: write a timetable
// step, write an edge, write a segment, or query the position at a time.
// Writes return nothing; each query returns one item on m_*, with m_tuser
// high when a visible position was found (all fields zero otherwise).
// cfg_* sets the number of valid timetable steps; it is always ready and
// must only be written while the unit is idle.
// A write latches the item and then writes it to its table. A query's time
// grows with the number of timetable steps scanned and the number of segment
// reads (binary search plus heading window); four passes through the shared
// one-bit-per-cycle divider dominate. One item is in work at a time.
// The next item is taken as soon as the unit is idle, even while the last
// result still waits in the output register; a new result is held back until
// the receiver takes the old one, and m_tdata/m_tuser hold while stalled.
// Reset clears the step count and the output valid; table contents are
// undefined until written.
module timed_polyline_position_unit import tpp_pkg::*; #(
  parameter int MAX_STEPS         = TPP_MAX_STEPS,
  parameter int MAX_EDGES         = TPP_MAX_EDGES,
  parameter int MAX_SEGMENTS      = TPP_MAX_SEGMENTS,
  parameter int MAX_EDGE_SEGMENTS = TPP_MAX_EDGE_SEGMENTS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // index, geo, reverse, time_value, seg_x0, seg_y0, seg_x1, seg_y1,
  // length_value, edge_first, edge_count
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // action
  input  logic [1:0]            s_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [8:0]            cfg_data,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // pos_x, pos_y, head_dx, head_dy, edge_slot
  output logic [OUT_DATA_W-1:0] m_tdata,
  // found
  output logic                  m_tuser
);

  tpp_cmd_t cmd;
  tpp_sts_t sts;

  assign cfg_ready = 1'b1;

  tpp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tpp_dp #(
    .MAX_STEPS         (MAX_STEPS),
    .MAX_EDGES         (MAX_EDGES),
    .MAX_SEGMENTS      (MAX_SEGMENTS),
    .MAX_EDGE_SEGMENTS (MAX_EDGE_SEGMENTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

// ===== hw/rtl/tpp_checker.sv =====
module tpp_checker import tpp_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic [IN_DATA_W-1:0]  s_tdata,
  input logic [1:0]            s_tuser,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic [8:0]            cfg_data,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic                  m_tuser
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("miss result carries data");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("item taken while previous one in work");

endmodule

bind timed_polyline_position_unit tpp_checker u_tpp_checker (.*);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import tpp_pkg::*;

  typedef struct packed {
    logic              found;
    logic [5:0]        slot;
    logic [16:0]       hdy;
    logic [16:0]       hdx;
    logic [23:0]       py;
    logic [23:0]       px;
  } position_t;

  typedef struct {
    tpp_act_t    act;
    logic [9:0]  idx;
    logic [6:0]  geo;
    logic        rev;
    logic [31:0] tv;
    logic [15:0] x0, y0, x1, y1;
    logic [23:0] len;
    logic [9:0]  efirst;
    logic [6:0]  ecount;
  } item_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [1:0]            s_tuser = ACT_STEP;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [8:0]            cfg_data = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;

  // predictor state
  int unsigned        steps_cfg;
  logic signed [6:0]  p_step_geo [TPP_MAX_STEPS];
  logic               p_step_rev [TPP_MAX_STEPS];
  logic [31:0]        p_step_end [TPP_MAX_STEPS];
  logic [9:0]         p_edge_base [TPP_MAX_EDGES];
  logic [6:0]         p_edge_segs [TPP_MAX_EDGES];
  logic [23:0]        p_edge_len [TPP_MAX_EDGES];
  logic signed [15:0] p_sx0 [TPP_MAX_SEGMENTS];
  logic signed [15:0] p_sy0 [TPP_MAX_SEGMENTS];
  logic signed [15:0] p_sx1 [TPP_MAX_SEGMENTS];
  logic signed [15:0] p_sy1 [TPP_MAX_SEGMENTS];
  logic [23:0]        p_seg_end [TPP_MAX_SEGMENTS];

  position_t pending_pos[$];
  int        errors = 0;
  int        n_items = 0;
  int        n_hits = 0;
  int        n_misses = 0;

  timed_polyline_position_unit u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #2 clk = ~clk;

  function automatic longint seg_end_at(int unsigned i);
    return longint'(p_seg_end[i % TPP_MAX_SEGMENTS]);
  endfunction

  function automatic longint lerp_q8(longint p0, longint p1, longint off, longint span);
    longint num, q;
    if (span <= 0) return p0 * 256;
    if (off < 0) off = 0;
    if (off > span) off = span;
    num = (p1 - p0) * 256 * off;
    q = num / span;
    if ((num % span != 0) && (num < 0)) q--;
    return p0 * 256 + q;
  endfunction

  function automatic position_t locate(logic [31:0] tq);
    position_t r;
    int unsigned cnt, s, n, base, lo, hi, mid, lft, rgt, sl, sr;
    logic [31:0] dur, t;
    logic signed [6:0] g;
    logic rv;
    longint start, span, el, total, ln, prev, sspan, off, px, py, hx, hy;
    r = '0;
    cnt = (steps_cfg > TPP_MAX_STEPS) ? TPP_MAX_STEPS : steps_cfg;
    if (cnt == 0) return r;
    dur = p_step_end[cnt-1];
    if (dur == 0) return r;
    t = tq % dur;
    s = 0;
    while (s + 1 < cnt && t >= p_step_end[s]) s++;
    g = p_step_geo[s];
    if (g < 0) return r;
    rv = p_step_rev[s];
    start = s ? longint'(p_step_end[s-1]) : 0;
    span = longint'(p_step_end[s]) - start;
    el = longint'(t) - start;
    total = longint'(p_edge_len[g]);
    ln = 0;
    if (span > 0) begin
      if (el < 0) el = 0;
      if (el > span) el = span;
      ln = ((rv ? span - el : el) * total) / span;
    end
    n = p_edge_segs[g];
    if (n == 0) n = 1;
    if (n > TPP_MAX_EDGE_SEGMENTS) n = TPP_MAX_EDGE_SEGMENTS;
    base = p_edge_base[g];
    lo = 0;
    hi = n - 1;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (seg_end_at(base + mid) < ln) lo = mid + 1;
      else hi = mid;
    end
    sl = (base + lo) % TPP_MAX_SEGMENTS;
    prev = lo ? seg_end_at(base + lo - 1) : 0;
    sspan = seg_end_at(base + lo) - prev;
    off = ln - prev;
    px = lerp_q8(p_sx0[sl], p_sx1[sl], off, sspan);
    py = lerp_q8(p_sy0[sl], p_sy1[sl], off, sspan);
    lft = lo;
    rgt = lo;
    while (lft > 0 && seg_end_at(base + lft - 1) > ln - 1536) lft--;
    while (rgt + 1 < n && seg_end_at(base + rgt) < ln + 1536) rgt++;
    sl = (base + lft) % TPP_MAX_SEGMENTS;
    sr = (base + rgt) % TPP_MAX_SEGMENTS;
    hx = longint'(p_sx1[sr]) - longint'(p_sx0[sl]);
    hy = longint'(p_sy1[sr]) - longint'(p_sy0[sl]);
    if (rv) begin
      hx = -hx;
      hy = -hy;
    end
    r.found = 1'b1;
    r.px = px[23:0];
    r.py = py[23:0];
    r.hdx = hx[16:0];
    r.hdy = hy[16:0];
    r.slot = g[5:0];
    return r;
  endfunction

  function automatic item_t junk_item();
    item_t it;
    it.act = ACT_QUERY;
    it.idx = 10'($urandom);
    it.geo = 7'($urandom);
    it.rev = 1'($urandom);
    it.tv = $urandom;
    it.x0 = 16'($urandom);
    it.y0 = 16'($urandom);
    it.x1 = 16'($urandom);
    it.y1 = 16'($urandom);
    it.len = 24'($urandom);
    it.efirst = 10'($urandom);
    it.ecount = 7'($urandom);
    return it;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_item(item_t it);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser <= it.act;
    s_tdata <= {5'b0, it.ecount, it.efirst, it.len, it.y1, it.x1, it.y0, it.x0,
                it.tv, it.rev, it.geo, it.idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n_items++;
    case (it.act)
      ACT_STEP: begin
        if (it.idx < TPP_MAX_STEPS) begin
          p_step_geo[it.idx] = it.geo;
          p_step_rev[it.idx] = it.rev;
          p_step_end[it.idx] = it.tv;
        end
      end
      ACT_EDGE: begin
        if (it.idx < TPP_MAX_EDGES) begin
          p_edge_base[it.idx] = it.efirst;
          p_edge_segs[it.idx] = it.ecount;
          p_edge_len[it.idx] = it.len;
        end
      end
      ACT_SEG: begin
        p_sx0[it.idx] = it.x0;
        p_sy0[it.idx] = it.y0;
        p_sx1[it.idx] = it.x1;
        p_sy1[it.idx] = it.y1;
        p_seg_end[it.idx] = it.len;
      end
      default: pending_pos.push_back(locate(it.tv));
    endcase
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic put_step(int unsigned idx, logic [6:0] geo, logic rev, logic [31:0] t_end);
    item_t it;
    it = junk_item();
    it.act = ACT_STEP;
    it.idx = 10'(idx);
    it.geo = geo;
    it.rev = rev;
    it.tv = t_end;
    send_item(it);
  endtask

  task automatic put_edge(int unsigned idx, logic [9:0] first, logic [6:0] count,
                          logic [23:0] len);
    item_t it;
    it = junk_item();
    it.act = ACT_EDGE;
    it.idx = 10'(idx);
    it.efirst = first;
    it.ecount = count;
    it.len = len;
    send_item(it);
  endtask

  task automatic put_seg(int unsigned idx, logic [23:0] seg_end);
    item_t it;
    it = junk_item();
    it.act = ACT_SEG;
    it.idx = 10'(idx);
    it.len = seg_end;
    if ($urandom_range(0, 2) == 0) begin
      it.x0 = 16'($urandom_range(0, 400) - 200);
      it.y0 = 16'($urandom_range(0, 400) - 200);
      it.x1 = 16'($urandom_range(0, 400) - 200);
      it.y1 = 16'($urandom_range(0, 400) - 200);
    end
    send_item(it);
  endtask

  task automatic ask(logic [31:0] t);
    item_t it;
    it = junk_item();
    it.act = ACT_QUERY;
    it.tv = t;
    send_item(it);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_pos.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_steps(logic [8:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    steps_cfg = v;
  endtask

  // timetable empty and tables loaded so every later read hits written entries
  task automatic test_empty_and_load();
    logic [31:0] acc;
    set_steps(9'd0);
    ask(32'd0);
    ask(32'hFFFF_FFFF);
    put_seg(0, 24'd2000);
    for (int e = 0; e < TPP_MAX_EDGES; e++)
      put_edge(e, 10'd0, 7'd1, 24'($urandom_range(0, 4000)));
    acc = 0;
    for (int s = 0; s < TPP_MAX_STEPS; s++) begin
      acc = acc + $urandom_range(0, 300);
      put_step(s, 7'($urandom_range(0, 127)), 1'($urandom), acc);
    end
    put_step(300, 7'd5, 1'b0, 32'd7);
    put_edge(1023, 10'd5, 7'd3, 24'd9);
  endtask

  task automatic test_step_count_extremes();
    set_steps(9'd256);
    ask(32'd0);
    ask(32'hFFFF_FFFF);
    repeat (4) ask($urandom);
    set_steps(9'd511);
    ask(32'hFFFF_FFFF);
    repeat (3) ask($urandom);
  endtask

  task automatic test_special_steps();
    put_step(0, 7'd0, 1'b0, 32'd0);
    set_steps(9'd1);
    ask(32'd12);
    put_step(0, 7'h7F, 1'b0, 32'd100);
    ask(32'd50);
    put_step(0, 7'h40, 1'b1, 32'd100);
    ask(32'd99);
  endtask

  task automatic build_track(bit big);
    int unsigned slots[8];
    int unsigned ne, n, base, ns, cnt_v;
    logic [23:0] acc;
    logic [31:0] tacc;
    logic [6:0] cnt_f;
    logic [6:0] g;
    ne = $urandom_range(1, 4);
    for (int e = 0; e < ne; e++) begin
      slots[e] = (big && e == 0) ? 63 : $urandom_range(0, 63);
      if (big && e == 0) n = 64;
      else if ($urandom_range(0, 9) == 0) n = $urandom_range(7, 20);
      else n = $urandom_range(1, 5);
      base = (big && e == 0) ? 1000 : $urandom_range(0, 1023);
      acc = 0;
      for (int k = 0; k < n; k++) begin
        case ($urandom_range(0, 19))
          0: acc = acc;
          1: acc = 24'($urandom);
          2: acc = 24'(acc + $urandom_range(2000, 9000));
          default: acc = 24'(acc + $urandom_range(1, 1600));
        endcase
        put_seg((base + k) % TPP_MAX_SEGMENTS, acc);
      end
      cnt_f = 7'(n);
      if (n == 1 && $urandom_range(0, 1)) cnt_f = 0;
      if (n == 64 && $urandom_range(0, 1)) cnt_f = 7'($urandom_range(65, 127));
      put_edge(slots[e], 10'(base), cnt_f, ($urandom_range(0, 7) == 0) ? 24'($urandom) : acc);
    end
    ns = big ? 16 : $urandom_range(1, 8);
    tacc = 0;
    for (int s = 0; s < ns; s++) begin
      case ($urandom_range(0, 19))
        0: tacc = tacc;
        1: tacc = $urandom;
        default: tacc = tacc + $urandom_range(1, 500);
      endcase
      if ($urandom_range(0, 6) == 0) g = 7'($urandom_range(64, 127));
      else g = 7'(slots[$urandom_range(0, ne - 1)]);
      put_step(s, g, 1'($urandom), tacc);
    end
    cnt_v = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 300) : ns;
    if (cnt_v != steps_cfg || $urandom_range(0, 1)) set_steps(9'(cnt_v));
    repeat ($urandom_range(8, 20)) begin
      if ($urandom_range(0, 9) < 7) ask($urandom_range(0, p_step_end[ns - 1] + 32'd3));
      else ask($urandom);
    end
  endtask

  task automatic test_tracks();
    build_track(1'b1);
    while (n_items < 1850) begin
      build_track($urandom_range(0, 19) == 0);
      if ($urandom_range(0, 9) == 0) begin
        item_t it;
        it = junk_item();
        it.act = ($urandom_range(0, 1)) ? ACT_STEP : ACT_EDGE;
        it.idx = 10'($urandom_range(256, 1023));
        send_item(it);
      end
    end
  endtask

  // output side stalls
  initial begin
    int r;
    @(negedge rst);
    forever begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        m_tready <= 1'b1;
        repeat ($urandom_range(50, 400)) @(posedge clk);
      end else begin
        m_tready <= (r < 75);
        repeat ((r >= 95) ? $urandom_range(10, 80) : $urandom_range(1, 4)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    position_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tuser, m_tdata};
      if (pending_pos.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, got);
        errors++;
      end else begin
        want = pending_pos.pop_front();
        if (got.found) n_hits++;
        else n_misses++;
        if (got.found !== want.found || got.px !== want.px || got.py !== want.py ||
            got.hdx !== want.hdx || got.hdy !== want.hdy || got.slot !== want.slot) begin
          $display("%0t: mismatch exp found=%0b x=%h y=%h hx=%h hy=%h slot=%0d", $realtime,
                   want.found, want.px, want.py, want.hdx, want.hdy, want.slot);
          $display("%0t:          got found=%0b x=%h y=%h hx=%h hy=%h slot=%0d", $realtime,
                   got.found, got.px, got.py, got.hdx, got.hdy, got.slot);
          errors++;
        end
      end
    end
  end

  initial begin
    #40_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    steps_cfg = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_and_load();
    test_step_count_extremes();
    test_special_steps();
    test_tracks();
    drain();
    repeat (200) @(posedge clk);
    $display("sent %0d items; %0d positions found, %0d queries with nothing reported",
             n_items, n_hits, n_misses);
    if (errors == 0 && pending_pos.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
